>>> rtl/core/gscs_pkg.sv
// Shared constants, types and helper functions for the GNSS sentence checker and splitter.
package gscs_pkg;

   localparam int HEADER_LENGTH = 6;
   localparam int HDR_POS_WIDTH = $clog2(HEADER_LENGTH + 1);
   localparam int HEADER_WIDTH  = 48;
   localparam logic [HEADER_WIDTH-1:0] HEADER_RESET = 48'h2447_5046_5044; // "$GPFPD"

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic CSR_IDX_HEADER = 1'b0;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   localparam logic [4:0] FC_STATUS   = 5'd15;
   localparam logic [4:0] FC_CHECKSUM = 5'd16;
   localparam logic [4:0] FC_LINE_END = 5'd17;
   localparam logic [4:0] FC_COMMA    = 5'd18;
   localparam logic [4:0] FC_IGNORED  = 5'd19;

   localparam logic [4:0] COMMA_DATA_LIMIT = 5'd15;
   localparam logic [4:0] COMMA_SATURATE   = 5'd16;
   localparam logic [2:0] TAIL_STATUS_END  = 3'd2;
   localparam logic [2:0] TAIL_SATURATE    = 3'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [4:0] field_code;
      logic       is_last;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            empty;
      logic            full;
      queue_entry_type head;
   } queue_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CH_ZERO + {4'd0, nib};
      end else begin
         return CH_UPPER_A + {4'd0, nib} - 8'd10;
      end
   endfunction

endpackage

>>> rtl/core/gscs_req_if.sv
// Input channel interface: one received character and its chunk-end mark.
interface gscs_req_if
   import gscs_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source(output valid, output rx_byte, output chunk_end, input ready);
   modport sink(input valid, input rx_byte, input chunk_end, output ready);
endinterface

>>> rtl/core/gscs_rsp_if.sv
// Result channel interface: tagged character with frame status.
interface gscs_rsp_if
   import gscs_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [4:0] field_code;
   logic       is_last;
   logic       frame_ok;

   modport source(output valid, output out_byte, output field_code, output is_last,
                  output frame_ok, input ready);
   modport sink(input valid, input out_byte, input field_code, input is_last,
                input frame_ok, output ready);
endinterface

>>> rtl/core/gscs_tagger.sv
// Front stage: accepts characters, counts commas and assigns each a field code.
module gscs_tagger
   import gscs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   gscs_req_if.sink         req_chan,
   input  queue_status_type q_status,
   output queue_push_type   q_push
);

   logic [4:0] comma_count_ff, comma_count_in;
   logic [2:0] tail_pos_ff, tail_pos_in;
   logic [4:0] code;
   logic       accept;

   assign req_chan.ready = !q_status.full;
   assign accept = req_chan.valid && !q_status.full;

   always_comb begin
      comma_count_in = comma_count_ff;
      tail_pos_in    = tail_pos_ff;
      code           = FC_IGNORED;
      if (req_chan.rx_byte == CH_COMMA) begin
         if (comma_count_ff < COMMA_SATURATE) begin
            comma_count_in = comma_count_ff + 5'd1;
         end
         code = FC_COMMA;
      end else if (comma_count_ff < COMMA_DATA_LIMIT) begin
         code = comma_count_ff;
      end else if (comma_count_ff > COMMA_DATA_LIMIT) begin
         code = FC_IGNORED;
      end else begin
         if (tail_pos_ff < TAIL_SATURATE) begin
            tail_pos_in = tail_pos_ff + 3'd1;
         end
         if (tail_pos_ff < TAIL_STATUS_END) begin
            code = FC_STATUS;
         end else if (tail_pos_ff < TAIL_SATURATE) begin
            code = FC_CHECKSUM;
         end else begin
            code = FC_LINE_END;
         end
      end
      if (req_chan.chunk_end) begin
         comma_count_in = '0;
         tail_pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comma_count_ff <= '0;
         tail_pos_ff    <= '0;
      end else if (accept) begin
         comma_count_ff <= comma_count_in;
         tail_pos_ff    <= tail_pos_in;
      end
   end

   assign q_push.push             = accept;
   assign q_push.entry.rx_byte    = req_chan.rx_byte;
   assign q_push.entry.field_code = code;
   assign q_push.entry.is_last    = req_chan.chunk_end;

endmodule

>>> rtl/core/gscs_queue.sv
// Small first-in first-out queue between the tagging and checking stages.
module gscs_queue
   import gscs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_push_type   q_push,
   input  logic             pop,
   output queue_status_type q_status
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);

   queue_entry_type        entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign q_status.head  = entries_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_WIDTH'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_WIDTH'(1);
         end
      end
   end

endmodule

>>> rtl/core/gscs_checker.sv
// Back stage: header and XOR checksum checking with a two-byte tail delay and output register.
module gscs_checker
   import gscs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [HEADER_WIDTH-1:0] expected_header,
   input  queue_status_type        q_status,
   output logic                    pop,
   gscs_rsp_if.source              rsp_chan
);

   typedef enum logic [1:0] {
      PH_WAIT_DOLLAR,
      PH_SUMMING,
      PH_CAPTURE
   } phase_type;

   logic [7:0]               hold0_ff, hold0_in, hold1_ff, hold1_in;
   logic [1:0]               hold_count_ff, hold_count_in;
   logic [HDR_POS_WIDTH-1:0] hdr_pos_ff, hdr_pos_in;
   logic                     hdr_match_ff, hdr_match_in;
   phase_type                phase_ff, phase_in, phase_mid;
   logic [7:0]               xor_sum_ff, xor_sum_in;
   logic [1:0]               digit_count_ff, digit_count_in;
   logic [7:0]               cap0_ff, cap0_in, cap1_ff, cap1_in;

   logic                     rsp_valid_ff;
   logic [7:0]               rsp_byte_ff;
   logic [4:0]               rsp_code_ff;
   logic                     rsp_last_ff, rsp_ok_ff;

   logic                     do_check;
   logic [7:0]               cb, want;
   logic                     frame_ok;
   queue_entry_type          e;

   assign e   = q_status.head;
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      want = '0;
      for (int p = 0; p < HEADER_LENGTH; p++) begin
         if (hdr_pos_ff == HDR_POS_WIDTH'(p)) begin
            want = expected_header[8*(HEADER_LENGTH-1-p) +: 8];
         end
      end
   end

   always_comb begin
      do_check       = (hold_count_ff == 2'd2);
      cb             = hold0_ff;
      hold0_in       = hold0_ff;
      hold1_in       = hold1_ff;
      hold_count_in  = hold_count_ff;
      hdr_pos_in     = hdr_pos_ff;
      hdr_match_in   = hdr_match_ff;
      phase_in       = phase_ff;
      phase_mid      = phase_ff;
      xor_sum_in     = xor_sum_ff;
      digit_count_in = digit_count_ff;
      cap0_in        = cap0_ff;
      cap1_in        = cap1_ff;

      if (do_check) begin
         if (hdr_pos_ff < HDR_POS_WIDTH'(HEADER_LENGTH)) begin
            if (cb != want) begin
               hdr_match_in = 1'b0;
            end
            hdr_pos_in = hdr_pos_ff + HDR_POS_WIDTH'(1);
         end
         if (phase_ff == PH_CAPTURE) begin
            if (digit_count_ff == 2'd0) begin
               cap0_in = cb;
            end else if (digit_count_ff == 2'd1) begin
               cap1_in = cb;
            end
            if (digit_count_ff < 2'd3) begin
               digit_count_in = digit_count_ff + 2'd1;
            end
         end
         // A star ends the summed span and is itself not summed.
         if (cb == CH_STAR) begin
            phase_mid = PH_CAPTURE;
         end
         if (phase_mid == PH_SUMMING) begin
            xor_sum_in = xor_sum_ff ^ cb;
         end
         phase_in = (cb == CH_DOLLAR) ? PH_SUMMING : phase_mid;
         hold0_in = hold1_ff;
         hold1_in = e.rx_byte;
      end else begin
         if (hold_count_ff[0]) begin
            hold1_in = e.rx_byte;
         end else begin
            hold0_in = e.rx_byte;
         end
         hold_count_in = hold_count_ff + 2'd1;
      end

      frame_ok = hdr_match_in && (hdr_pos_in == HDR_POS_WIDTH'(HEADER_LENGTH)) &&
                 (digit_count_in == 2'd2) &&
                 (cap0_in == hex_digit(xor_sum_in[7:4])) &&
                 (cap1_in == hex_digit(xor_sum_in[3:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold0_ff       <= '0;
         hold1_ff       <= '0;
         hold_count_ff  <= '0;
         hdr_pos_ff     <= '0;
         hdr_match_ff   <= 1'b1;
         phase_ff       <= PH_WAIT_DOLLAR;
         xor_sum_ff     <= '0;
         digit_count_ff <= '0;
         cap0_ff        <= '0;
         cap1_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            if (e.is_last) begin
               hold0_ff       <= '0;
               hold1_ff       <= '0;
               hold_count_ff  <= '0;
               hdr_pos_ff     <= '0;
               hdr_match_ff   <= 1'b1;
               phase_ff       <= PH_WAIT_DOLLAR;
               xor_sum_ff     <= '0;
               digit_count_ff <= '0;
               cap0_ff        <= '0;
               cap1_ff        <= '0;
            end else begin
               hold0_ff       <= hold0_in;
               hold1_ff       <= hold1_in;
               hold_count_ff  <= hold_count_in;
               hdr_pos_ff     <= hdr_pos_in;
               hdr_match_ff   <= hdr_match_in;
               phase_ff       <= phase_in;
               xor_sum_ff     <= xor_sum_in;
               digit_count_ff <= digit_count_in;
               cap0_ff        <= cap0_in;
               cap1_ff        <= cap1_in;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_byte_ff <= e.rx_byte;
         rsp_code_ff <= e.field_code;
         rsp_last_ff <= e.is_last;
         rsp_ok_ff   <= e.is_last && frame_ok;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.field_code = rsp_code_ff;
   assign rsp_chan.is_last    = rsp_last_ff;
   assign rsp_chan.frame_ok   = rsp_ok_ff;

endmodule

>>> rtl/core/gnss_sentence_checker_splitter_core.sv
// Top level of the GNSS sentence checker and splitter with its control register port.
//
// Usage: received characters enter one per transaction on req_chan, with chunk_end set on
// the final character of a chunk. Every character comes back as exactly one transaction on
// rsp_chan, unchanged and tagged with a field code: data fields 0-14 counted by commas,
// then status, checksum text and line end after the fifteenth comma, comma, or ignored.
// On the transaction for the final character, frame_ok reports whether the sentence
// started with the programmed header and carried a correct two-digit uppercase hex XOR
// checksum; the last two characters of a chunk (the line end) are left out of checking.
// Each accepted character passes through the queue and then the output register before its
// result is presented, and one character is accepted per cycle while the queue is not
// full. The front stage tags characters and writes them into a two-entry queue; the back
// stage checks them and owns the output register, so rate is set by the single pass of
// each character through the checker.
// When the receiver stalls, the output register holds its result, the queue fills and
// req_chan.ready drops only once the queue is full; nothing is lost or repeated.
// Reset clears all sentence state and loads the header register with "$GPFPD". The
// header register (index 0, byte address 0, 64-bit data, upper 16 bits read as zero)
// is written over the APB-style port and should be changed only while the block is idle.
module gnss_sentence_checker_splitter_core
   import gscs_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   gscs_req_if.sink                  req_chan,
   gscs_rsp_if.source                rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [HEADER_WIDTH-1:0] header_ff;
   logic                    csr_write;
   logic                    csr_hit;
   queue_push_type          q_push;
   queue_status_type        q_status;
   logic                    q_pop;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;
   // Registers sit on 8-byte boundaries, so the index is the address bit above the offset.
   assign csr_hit    = (csr_paddr[3] == CSR_IDX_HEADER);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (csr_write && csr_hit) begin
         header_ff <= csr_pwdata[HEADER_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {{(CSR_DATA_WIDTH-HEADER_WIDTH){1'b0}}, header_ff};
      end
   end

   // Front stage: tagging by comma count.
   gscs_tagger u_tagger (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // Decoupling queue between tagging and checking.
   gscs_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (q_pop),
      .q_status (q_status)
   );

   // Back stage: header and checksum checking, result register.
   gscs_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .expected_header (header_ff),
      .q_status        (q_status),
      .pop             (q_pop),
      .rsp_chan        (rsp_chan)
   );

endmodule
